FILE: sv/tccs_pkg.sv
package tccs_pkg;

   localparam int HDR_BYTES = 20;
   localparam int OPT_BYTES = 12;
   localparam logic [3:0] HDR_WORDS = 4'(HDR_BYTES / 4);
   localparam logic [3:0] OPT_HDR_WORDS = 4'((HDR_BYTES + OPT_BYTES) / 4);

   localparam logic [31:0] FIRST_SEQ = 32'd10;

   localparam logic [7:0] FLAG_FIN = 8'h01;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_PSH = 8'h08;
   localparam logic [7:0] FLAG_ACK = 8'h10;
   localparam int FIN_BIT = 0;
   localparam int SYN_BIT = 1;

   localparam int RESULT_DEPTH = 4;
   localparam int PTR_W = $clog2(RESULT_DEPTH);
   localparam int COUNT_W = PTR_W + 1;

   typedef enum logic [1:0] {
      OP_OPEN    = 2'd0,
      OP_SEGMENT = 2'd1,
      OP_SEND    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_HANDSHAKE = 2'd1,
      ST_TRANSFER  = 2'd2,
      ST_CLOSED    = 2'd3
   } conn_state_type;

   typedef enum logic [1:0] {
      SRC_NONE    = 2'd0,
      SRC_REQUEST = 2'd1,
      SRC_APP     = 2'd2
   } psrc_type;

   typedef enum logic [1:0] {
      CSR_LOCAL_PORT     = 2'd0,
      CSR_REMOTE_PORT    = 2'd1,
      CSR_REMOTE_ADDRESS = 2'd2,
      CSR_REQUEST_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] peer_address;
      logic [15:0] rx_dest_port;
      logic [7:0]  rx_flags;
      logic [31:0] rx_sequence;
      logic [31:0] rx_ack;
      logic [3:0]  rx_offset_words;
      logic [15:0] segment_length;
   } item_type;

   typedef struct packed {
      logic [31:0] dest_address;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  flags;
      logic        options_present;
      logic [15:0] payload_length;
      psrc_type    payload_source;
      logic [15:0] delivered_length;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [31:0] remote_address;
      logic [15:0] request_length;
   } csr_type;

endpackage

FILE: sv/tccs_core.sv
module tccs_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tccs_pkg::item_type req_item,
   input  tccs_pkg::csr_type  csr,
   input  logic               room,
   output tccs_pkg::push_type push
);
   import tccs_pkg::*;

   logic           stage_valid_ff, stage_valid_in;
   item_type       stage_ff;
   conn_state_type conn_state_ff, conn_state_in;
   logic [31:0]    sent_sequence_ff, sent_sequence_in;
   logic [31:0]    sent_ack_ff, sent_ack_in;

   logic        fire;
   logic        accept;
   logic        is_open, is_send, port_match;
   logic        syn_reply, fin_reply, data_reply;
   logic [5:0]  hdr_len;
   logic [15:0] rx_payload;
   logic [31:0] rseq_plus_one;
   logic [31:0] rseq_plus_payload;

   assign fire      = stage_valid_ff && room;
   assign req_stall = stage_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign stage_valid_in = accept || (stage_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= req_item;
      end
   end

   // decode of the held item
   assign is_open    = (stage_ff.op == OP_OPEN);
   assign is_send    = (stage_ff.op == OP_SEND);
   assign port_match = (stage_ff.op == OP_SEGMENT) && (stage_ff.rx_dest_port == csr.local_port);
   assign hdr_len    = {stage_ff.rx_offset_words, 2'b00};
   assign rx_payload = stage_ff.segment_length - {10'd0, hdr_len};

   assign syn_reply  = port_match && (conn_state_ff == ST_HANDSHAKE)
                       && stage_ff.rx_flags[SYN_BIT];
   assign fin_reply  = port_match && (conn_state_ff == ST_TRANSFER)
                       && stage_ff.rx_flags[FIN_BIT];
   assign data_reply = port_match && (conn_state_ff == ST_TRANSFER)
                       && !stage_ff.rx_flags[FIN_BIT]
                       && (stage_ff.segment_length > {10'd0, hdr_len});

   assign rseq_plus_one     = stage_ff.rx_sequence + 32'd1;
   assign rseq_plus_payload = stage_ff.rx_sequence + {16'd0, rx_payload};

   // next state
   always_comb begin
      conn_state_in    = conn_state_ff;
      sent_sequence_in = sent_sequence_ff;
      sent_ack_in      = sent_ack_ff;
      if (fire) begin
         if (is_open) begin
            conn_state_in    = ST_HANDSHAKE;
            sent_sequence_in = FIRST_SEQ;
            sent_ack_in      = '0;
         end else if (is_send) begin
            sent_sequence_in = sent_sequence_ff + {16'd0, stage_ff.segment_length};
         end else if (syn_reply) begin
            conn_state_in    = ST_TRANSFER;
            sent_sequence_in = stage_ff.rx_ack + {16'd0, csr.request_length};
            sent_ack_in      = rseq_plus_one;
         end else if (fin_reply) begin
            conn_state_in    = ST_CLOSED;
            sent_sequence_in = stage_ff.rx_ack;
            sent_ack_in      = rseq_plus_one;
         end else if (data_reply) begin
            sent_sequence_in = stage_ff.rx_ack;
            sent_ack_in      = rseq_plus_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_state_ff    <= ST_IDLE;
         sent_sequence_ff <= '0;
         sent_ack_ff      <= '0;
      end else begin
         conn_state_ff    <= conn_state_in;
         sent_sequence_ff <= sent_sequence_in;
         sent_ack_ff      <= sent_ack_in;
      end
   end

   // result descriptors
   always_comb begin
      push        = '0;
      push.first  = '0;
      push.second = '0;
      if (is_open) begin
         push.count                 = 2'd1;
         push.first.dest_address    = csr.remote_address;
         push.first.seq             = FIRST_SEQ;
         push.first.ack             = '0;
         push.first.flags           = FLAG_SYN;
         push.first.options_present = 1'b1;
         push.first.payload_source  = SRC_NONE;
         push.first.last            = 1'b1;
      end else if (is_send) begin
         push.count                 = 2'd1;
         push.first.dest_address    = csr.remote_address;
         push.first.seq             = sent_sequence_ff;
         push.first.ack             = sent_ack_ff;
         push.first.flags           = FLAG_PSH | FLAG_ACK;
         push.first.payload_length  = stage_ff.segment_length;
         push.first.payload_source  = SRC_APP;
         push.first.last            = 1'b1;
      end else if (syn_reply) begin
         push.count                  = 2'd2;
         push.first.dest_address     = stage_ff.peer_address;
         push.first.seq              = stage_ff.rx_ack;
         push.first.ack              = rseq_plus_one;
         push.first.flags            = FLAG_ACK;
         push.first.options_present  = 1'b1;
         push.first.payload_source   = SRC_NONE;
         push.second.dest_address    = stage_ff.peer_address;
         push.second.seq             = stage_ff.rx_ack;
         push.second.ack             = rseq_plus_one;
         push.second.flags           = FLAG_PSH | FLAG_ACK;
         push.second.options_present = 1'b1;
         push.second.payload_length  = csr.request_length;
         push.second.payload_source  = SRC_REQUEST;
         push.second.last            = 1'b1;
      end else if (fin_reply || data_reply) begin
         push.count                 = 2'd1;
         push.first.dest_address    = stage_ff.peer_address;
         push.first.seq             = stage_ff.rx_ack;
         push.first.ack             = fin_reply ? rseq_plus_one : rseq_plus_payload;
         push.first.flags           = FLAG_ACK;
         push.first.options_present = 1'b1;
         push.first.payload_source  = SRC_NONE;
         push.first.delivered_length = fin_reply ? 16'd0 : rx_payload;
         push.first.last            = 1'b1;
      end
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   a_open_enters_handshake: assert property (@(posedge clock) disable iff (reset)
      fire && is_open |=> conn_state_ff == ST_HANDSHAKE)
      else $error("open did not enter handshake");

   a_pair_only_from_handshake: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> conn_state_ff == ST_HANDSHAKE && fire)
      else $error("two results outside handshake");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !room |=> stage_valid_ff && $stable(stage_ff))
      else $error("held item lost while queue full");

   a_no_push_when_empty: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> push.count == 2'd0)
      else $error("result pushed without an item");

endmodule

FILE: sv/tccs_fifo.sv
module tccs_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  tccs_pkg::push_type   push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tccs_pkg::result_type head
);
   import tccs_pkg::*;

   result_type        entries_ff [RESULT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic              pop;
   logic [PTR_W-1:0]  wr_next;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   // room for a two-result burst
   assign room      = (count_ff <= COUNT_W'(RESULT_DEPTH - 2));
   assign head      = entries_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + COUNT_W'(push.count) - COUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(RESULT_DEPTH))
      else $error("result queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      !room |-> push.count == 2'd0)
      else $error("push into full queue");

   a_drain_to_empty: assert property (@(posedge clock) disable iff (reset)
      pop && count_ff == COUNT_W'(1) && push.count == 2'd0 |=> !rsp_valid)
      else $error("queue not empty after last transfer");

endmodule

FILE: sv/tcp_client_segment_sequencer.sv
// TCP client segment sequencer, header level only.
// Input channel (req_*): one item per transfer, an open, a received segment
// header or an application send, taken when req_valid is high and req_stall
// low. Result channel (rsp_*): segment descriptors to emit, same valid/stall
// handshake; rsp_last marks the final descriptor caused by an item.
// Register port (csr_*): write-only, index 0 local port, 1 remote port,
// 2 remote address, 3 request length; write only while no item is in flight.
// An item is held in the input register, and its descriptors are
// written into the result queue, from which they are offered.
// Throughput: one item per cycle for items with one result or none, while the
// result queue has room; the SYN reply gives two descriptors, written into the
// queue together. The output side drains one descriptor per cycle while
// rsp_stall is low, from a four-entry result queue. When the receiver stalls,
// the queue fills; once fewer than two entries are free the input register holds its item and req_stall rises.
// Reset (synchronous) empties the queue, clears the input register, returns
// the connection to idle with zero sequence/ack numbers and loads the
// register defaults (local port 10000, others zero).
module tcp_client_segment_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_peer_address,
   input  logic [15:0] req_rx_dest_port,
   input  logic [7:0]  req_rx_flags,
   input  logic [31:0] req_rx_sequence,
   input  logic [31:0] req_rx_ack,
   input  logic [3:0]  req_rx_offset_words,
   input  logic [15:0] req_segment_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dest_address,
   output logic [15:0] rsp_src_port_out,
   output logic [15:0] rsp_dst_port_out,
   output logic [31:0] rsp_seq_out,
   output logic [31:0] rsp_ack_out,
   output logic [7:0]  rsp_flags_out,
   output logic [3:0]  rsp_header_words,
   output logic        rsp_options_present,
   output logic [15:0] rsp_payload_length,
   output logic [1:0]  rsp_payload_source,
   output logic [15:0] rsp_delivered_length,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import tccs_pkg::*;

   csr_type    csr_ff, csr_in;
   item_type   req_item;
   push_type   push;
   logic       room;
   result_type head;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOCAL_PORT:     csr_in.local_port     = csr_write_data[15:0];
            CSR_REMOTE_PORT:    csr_in.remote_port    = csr_write_data[15:0];
            CSR_REMOTE_ADDRESS: csr_in.remote_address = csr_write_data;
            CSR_REQUEST_LENGTH: csr_in.request_length = csr_write_data[15:0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.local_port     <= 16'd10000;
         csr_ff.remote_port    <= '0;
         csr_ff.remote_address <= '0;
         csr_ff.request_length <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign req_item.op              = req_op;
   assign req_item.peer_address    = req_peer_address;
   assign req_item.rx_dest_port    = req_rx_dest_port;
   assign req_item.rx_flags        = req_rx_flags;
   assign req_item.rx_sequence     = req_rx_sequence;
   assign req_item.rx_ack          = req_rx_ack;
   assign req_item.rx_offset_words = req_rx_offset_words;
   assign req_item.segment_length  = req_segment_length;

   tccs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .csr       (csr_ff),
      .room      (room),
      .push      (push)
   );

   tccs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   // user rule, not enforced: ports change only while idle; they come straight from the registers
   assign rsp_src_port_out     = csr_ff.local_port;
   assign rsp_dst_port_out     = csr_ff.remote_port;
   assign rsp_dest_address     = head.dest_address;
   assign rsp_seq_out          = head.seq;
   assign rsp_ack_out          = head.ack;
   assign rsp_flags_out        = head.flags;
   assign rsp_header_words     = head.options_present ? OPT_HDR_WORDS : HDR_WORDS;
   assign rsp_options_present  = head.options_present;
   assign rsp_payload_length   = head.payload_length;
   assign rsp_payload_source   = head.payload_source;
   assign rsp_delivered_length = head.delivered_length;
   assign rsp_last             = head.last;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tccs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 126;
   localparam int MAX_PRINTED = 100;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] dest_address;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  flags;
      logic [3:0]  header_words;
      logic        options_present;
      logic [15:0] payload_length;
      psrc_type    payload_source;
      logic [15:0] delivered_length;
      logic        last_flag;
   } segment_desc_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   item_type    req_item = '0;
   logic [1:0]  req_op;
   logic [31:0] req_peer_address;
   logic [15:0] req_rx_dest_port;
   logic [7:0]  req_rx_flags;
   logic [31:0] req_rx_sequence;
   logic [31:0] req_rx_ack;
   logic [3:0]  req_rx_offset_words;
   logic [15:0] req_segment_length;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_dest_address;
   logic [15:0] rsp_src_port_out;
   logic [15:0] rsp_dst_port_out;
   logic [31:0] rsp_seq_out;
   logic [31:0] rsp_ack_out;
   logic [7:0]  rsp_flags_out;
   logic [3:0]  rsp_header_words;
   logic        rsp_options_present;
   logic [15:0] rsp_payload_length;
   logic [1:0]  rsp_payload_source;
   logic [15:0] rsp_delivered_length;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_LOCAL_PORT;
   logic [31:0] csr_write_data = '0;

   assign req_op = req_item.op;
   assign req_peer_address = req_item.peer_address;
   assign req_rx_dest_port = req_item.rx_dest_port;
   assign req_rx_flags = req_item.rx_flags;
   assign req_rx_sequence = req_item.rx_sequence;
   assign req_rx_ack = req_item.rx_ack;
   assign req_rx_offset_words = req_item.rx_offset_words;
   assign req_segment_length = req_item.segment_length;

   tcp_client_segment_sequencer DUT (.*);

   item_type         pending_items[$];
   segment_desc_type expected_segments[$];
   csr_type          regs;
   conn_state_type   link_state;
   logic [31:0]      next_seq;
   logic [31:0]      last_ack;
   int unsigned      queued_items = 0;
   int unsigned      accepted_items = 0;
   int unsigned      mismatches = 0;
   int unsigned      quiet_cycles = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   bit               drain_hold = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   // every emitted segment moves the sequence on by its payload
   function automatic void emit_segment(logic [31:0] dst, logic [31:0] seq, logic [31:0] ack,
                                        logic [7:0] flags, logic opts, logic [15:0] plen,
                                        psrc_type psrc, logic [15:0] deliv, logic last_one);
      segment_desc_type s;
      s.dest_address = dst;
      s.src_port = regs.local_port;
      s.dst_port = regs.remote_port;
      s.seq = seq;
      s.ack = ack;
      s.flags = flags;
      s.header_words = opts ? OPT_HDR_WORDS : HDR_WORDS;
      s.options_present = opts;
      s.payload_length = plen;
      s.payload_source = psrc;
      s.delivered_length = deliv;
      s.last_flag = last_one;
      next_seq = seq + {16'd0, plen};
      last_ack = ack;
      expected_segments.push_back(s);
   endfunction

   function automatic void predict_segments(item_type it);
      logic [31:0] ack_num;
      logic [15:0] hdr_bytes;
      logic [15:0] data_bytes;
      hdr_bytes = {10'd0, it.rx_offset_words, 2'b00};
      case (it.op)
         OP_OPEN: begin
            link_state = ST_HANDSHAKE;
            emit_segment(regs.remote_address, FIRST_SEQ, 32'd0, FLAG_SYN, 1'b1, 16'd0,
                         SRC_NONE, 16'd0, 1'b1);
         end
         OP_SEND: begin
            emit_segment(regs.remote_address, next_seq, last_ack, FLAG_PSH | FLAG_ACK, 1'b0,
                         it.segment_length, SRC_APP, 16'd0, 1'b1);
         end
         OP_SEGMENT: begin
            if (it.rx_dest_port == regs.local_port) begin
               if (link_state == ST_HANDSHAKE) begin
                  if (it.rx_flags[SYN_BIT]) begin
                     ack_num = it.rx_sequence + 32'd1;
                     emit_segment(it.peer_address, it.rx_ack, ack_num, FLAG_ACK, 1'b1, 16'd0,
                                  SRC_NONE, 16'd0, 1'b0);
                     emit_segment(it.peer_address, it.rx_ack, ack_num, FLAG_PSH | FLAG_ACK,
                                  1'b1, regs.request_length, SRC_REQUEST, 16'd0, 1'b1);
                     link_state = ST_TRANSFER;
                  end
               end else if (link_state == ST_TRANSFER) begin
                  if (it.rx_flags[FIN_BIT]) begin
                     link_state = ST_CLOSED;
                     emit_segment(it.peer_address, it.rx_ack, it.rx_sequence + 32'd1, FLAG_ACK,
                                  1'b1, 16'd0, SRC_NONE, 16'd0, 1'b1);
                  end else if (it.segment_length > hdr_bytes) begin
                     data_bytes = it.segment_length - hdr_bytes;
                     emit_segment(it.peer_address, it.rx_ack,
                                  it.rx_sequence + {16'd0, data_bytes}, FLAG_ACK, 1'b1, 16'd0,
                                  SRC_NONE, data_bytes, 1'b1);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_segments(req_item);
            accepted_items++;
            if ($urandom_range(49) == 0) drain_hold = 1'b1;
         end
         if (drain_hold && expected_segments.size() == 0) drain_hold = 1'b0;
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && !drain_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_item <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      segment_desc_type got;
      segment_desc_type want;
      string bad;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.dest_address = rsp_dest_address;
            got.src_port = rsp_src_port_out;
            got.dst_port = rsp_dst_port_out;
            got.seq = rsp_seq_out;
            got.ack = rsp_ack_out;
            got.flags = rsp_flags_out;
            got.header_words = rsp_header_words;
            got.options_present = rsp_options_present;
            got.payload_length = rsp_payload_length;
            got.payload_source = psrc_type'(rsp_payload_source);
            got.delivered_length = rsp_delivered_length;
            got.last_flag = rsp_last;
            if (expected_segments.size() == 0) begin
               report_mismatch($sformatf("segment with none expected: %p", got));
            end else begin
               want = expected_segments.pop_front();
               bad = "";
               if (got.dest_address !== want.dest_address) bad = {bad, " dest_address"};
               if (got.src_port !== want.src_port) bad = {bad, " src_port"};
               if (got.dst_port !== want.dst_port) bad = {bad, " dst_port"};
               if (got.seq !== want.seq) bad = {bad, " seq"};
               if (got.ack !== want.ack) bad = {bad, " ack"};
               if (got.flags !== want.flags) bad = {bad, " flags"};
               if (got.header_words !== want.header_words) bad = {bad, " header_words"};
               if (got.options_present !== want.options_present) bad = {bad, " options"};
               if (got.payload_length !== want.payload_length) bad = {bad, " payload_length"};
               if (got.payload_source !== want.payload_source) bad = {bad, " payload_source"};
               if (got.delivered_length !== want.delivered_length) bad = {bad, " delivered"};
               if (got.last_flag !== want.last_flag) bad = {bad, " last"};
               if (bad != "") begin
                  report_mismatch($sformatf("bad%s: got %p expected %p", bad, got, want));
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic item_type make_item(logic [1:0] op, logic [31:0] peer, logic [15:0] port,
                                          logic [7:0] flags, logic [31:0] seq,
                                          logic [31:0] ack, logic [3:0] offset,
                                          logic [15:0] len);
      item_type it;
      it.op = op;
      it.peer_address = peer;
      it.rx_dest_port = port;
      it.rx_flags = flags;
      it.rx_sequence = seq;
      it.rx_ack = ack;
      it.rx_offset_words = offset;
      it.segment_length = len;
      return it;
   endfunction

   task automatic queue_item(item_type it);
      pending_items.push_back(it);
      queued_items++;
   endtask

   task automatic maybe_noise();
      logic [15:0] port;
      if ($urandom_range(6) == 0) begin
         port = ($urandom_range(1) == 0) ? regs.local_port : 16'($urandom);
         queue_item(make_item(2'($urandom_range(3)), $urandom, port, 8'($urandom), $urandom,
                              $urandom, 4'($urandom), 16'($urandom)));
      end
   endtask

   function automatic logic [15:0] send_length();
      case ($urandom_range(9))
         0: return 16'hFFFF;
         1: return 16'($urandom);
         default: return 16'($urandom_range(1500));
      endcase
   endfunction

   // usually an open, then a syn segment, some data and sends, then usually a fin
   task automatic add_session(inout int unsigned useful);
      logic [31:0] peer;
      logic [3:0]  offset;
      logic [15:0] len;
      int unsigned exchanges;
      peer = $urandom;
      if ($urandom_range(9) != 0) begin
         queue_item(make_item(OP_OPEN, $urandom, 16'($urandom), 8'($urandom), $urandom,
                              $urandom, 4'($urandom), 16'($urandom)));
         useful++;
      end
      maybe_noise();
      queue_item(make_item(OP_SEGMENT, peer, regs.local_port, 8'($urandom) | FLAG_SYN,
                           $urandom, $urandom, 4'($urandom), 16'($urandom)));
      useful++;
      exchanges = $urandom_range(6);
      repeat (exchanges) begin
         maybe_noise();
         if ($urandom_range(2) == 0) begin
            queue_item(make_item(OP_SEND, $urandom, 16'($urandom), 8'($urandom), $urandom,
                                 $urandom, 4'($urandom), send_length()));
         end else begin
            offset = ($urandom_range(7) == 0) ? 4'($urandom_range(4))
                                              : 4'($urandom_range(15, 5));
            len = ($urandom_range(5) == 0) ? 16'($urandom)
                  : 16'(offset) * 16'd4 + 16'($urandom_range(1460));
            queue_item(make_item(OP_SEGMENT, peer, regs.local_port, 8'($urandom) & ~FLAG_FIN,
                                 $urandom, $urandom, offset, len));
         end
         useful++;
      end
      if ($urandom_range(4) != 0) begin
         queue_item(make_item(OP_SEGMENT, peer, regs.local_port, 8'($urandom) | FLAG_FIN,
                              $urandom, $urandom, 4'($urandom), 16'($urandom)));
         useful++;
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_LOCAL_PORT:     regs.local_port = value[15:0];
         CSR_REMOTE_PORT:    regs.remote_port = value[15:0];
         CSR_REMOTE_ADDRESS: regs.remote_address = value;
         CSR_REQUEST_LENGTH: regs.request_length = value[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] lport, logic [15:0] rport, logic [31:0] raddr,
                            logic [15:0] rlen);
      write_reg(CSR_LOCAL_PORT, {16'd0, lport});
      write_reg(CSR_REMOTE_PORT, {16'd0, rport});
      write_reg(CSR_REMOTE_ADDRESS, raddr);
      write_reg(CSR_REQUEST_LENGTH, {16'd0, rlen});
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // items with no result may still be inside the block
   task automatic settle();
      while (accepted_items != queued_items || expected_segments.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned useful;
      logic [15:0] lp;
      regs.local_port = 16'd10000;
      regs.remote_port = 16'd0;
      regs.remote_address = 32'd0;
      regs.request_length = 16'd0;
      link_state = ST_IDLE;
      next_seq = 32'd0;
      last_ack = 32'd0;
      send_idle_pct = 28;
      recv_idle_pct = 63;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      configure(16'd10000, 16'd80, 32'hC0A8_0001, 16'hFFFF);
      lp = regs.local_port;
      // a segment, the unused op and a send before any open, then an open
      queue_item(make_item(OP_SEGMENT, 32'h0A00_0001, lp, FLAG_SYN, 0, 0, 4'd5, 16'd20));
      queue_item(make_item(OP_UNUSED, '1, lp, 8'hFF, '1, '1, 4'hF, 16'hFFFF));
      queue_item(make_item(OP_SEND, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      queue_item(make_item(OP_OPEN, 0, 0, 0, 0, 0, 0, 0));
      // handshake: wrong port, no syn, then syn with wrapping numbers
      queue_item(make_item(OP_SEGMENT, '1, lp ^ 16'h0001, FLAG_SYN, 0, 0, 4'd5, 16'd20));
      queue_item(make_item(OP_SEGMENT, '1, lp, 8'hFD, 0, 0, 4'd5, 16'd20));
      queue_item(make_item(OP_SEGMENT, '1, lp, 8'hFF, '1, 32'hFFFF_FFF0, 4'd5, 16'd20));
      // transfer: header only, short, largest payload, one byte, two sends, then a fin
      queue_item(make_item(OP_SEGMENT, 32'h1, lp, 8'h00, 32'h5, 32'h7, 4'd5, 16'd20));
      queue_item(make_item(OP_SEGMENT, 32'h1, lp, 8'h00, 32'h5, 32'h7, 4'hF, 16'd59));
      queue_item(make_item(OP_SEGMENT, 32'h2, lp, FLAG_ACK, 32'hFFFF_0000, 32'h9, 4'd0,
                           16'hFFFF));
      queue_item(make_item(OP_SEGMENT, 32'h3, lp, FLAG_ACK, 32'h100, 32'h200, 4'hF, 16'd61));
      queue_item(make_item(OP_SEND, 0, 0, 0, 0, 0, 0, 16'd0));
      queue_item(make_item(OP_SEND, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      queue_item(make_item(OP_SEGMENT, 32'h4, lp, FLAG_FIN, '1, 32'h10, 4'd5, 16'd20));
      // closed: segments ignored, send still goes out
      queue_item(make_item(OP_SEGMENT, 32'h4, lp, FLAG_SYN, 32'h1, 32'h1, 4'd5, 16'd20));
      queue_item(make_item(OP_SEGMENT, 32'h4, lp, FLAG_ACK, 32'h1, 32'h1, 4'd5, 16'd200));
      queue_item(make_item(OP_SEND, 0, 0, 0, 0, 0, 0, 16'd100));
      // reopen from closed, from handshake and from transfer, then the unused op, syn, data and fin
      queue_item(make_item(OP_OPEN, '1, '1, '1, '1, '1, '1, '1));
      queue_item(make_item(OP_OPEN, 0, 0, 0, 0, 0, 0, 0));
      queue_item(make_item(OP_SEGMENT, 32'h5, lp, FLAG_SYN, 32'h0, 32'h0, 4'd5, 16'd20));
      queue_item(make_item(OP_OPEN, 0, 0, 0, 0, 0, 0, 0));
      queue_item(make_item(OP_UNUSED, 0, lp, FLAG_SYN, 0, 0, 0, 0));
      queue_item(make_item(OP_SEGMENT, 32'h6, lp, 8'h12, 32'h77, 32'h88, 4'd8, 16'd32));
      queue_item(make_item(OP_SEGMENT, 32'h6, lp, FLAG_ACK, 32'h78, 32'h99, 4'd8, 16'd100));
      queue_item(make_item(OP_SEGMENT, 32'h6, lp, 8'h11, 32'h90, 32'h99, 4'd5, 16'd20));
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 4) begin
            send_idle_pct = 28;
            recv_idle_pct = 63;
         end else if (phase < 8) begin
            send_idle_pct = 63;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure((phase == 1) ? 16'd0 : (phase == 2) ? 16'hFFFF : 16'($urandom),
                   (phase == 3) ? 16'd0 : (phase == 4) ? 16'hFFFF : 16'($urandom),
                   (phase == 5) ? 32'd0 : (phase == 6) ? 32'hFFFF_FFFF : $urandom,
                   (phase == 7) ? 16'd0 : (phase == 8) ? 16'hFFFF
                                : 16'($urandom_range(2000)));
         useful = 0;
         while (useful < ITEMS_PER_PHASE) add_session(useful);
         settle();
      end

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: tcp_client_segment_sequencer.f
sv/tccs_pkg.sv
sv/tccs_core.sv
sv/tccs_fifo.sv
sv/tcp_client_segment_sequencer.sv
test/testbench.sv
